@@ rtl/purl_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// purl_pkg
// Shared types, character constants and helpers for the URL percent decoder.
// ----------------------------------------------------------------------------
package purl_pkg;

    // Characters with a special meaning in form-urlencoded text
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    // Most bytes one input word can give
    localparam int unsigned GRP_BYTES = 3;

    // Depth of the group queue between front and back
    localparam int unsigned QDEPTH  = 4;
    localparam int unsigned QPTR_W  = $clog2(QDEPTH);
    localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

    // Input word
    typedef struct packed {
        logic [7:0] in_char;
        logic       in_last;
    } t_in_word;

    // Output word
    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } t_out_word;

    // Bytes produced by one input word, oldest in entry 0
    typedef struct packed {
        logic [GRP_BYTES-1:0][7:0] bytes;
        logic [1:0]                cnt;
        logic                      last;
    } t_group;

    // Decoded hex digit
    typedef struct packed {
        logic       valid;
        logic [3:0] nib;
    } t_hex;

    // Escape decoding phase
    typedef enum logic [2:0] {
        PH_PLAIN = 3'b001,
        PH_PCT   = 3'b010,
        PH_HEX   = 3'b100
    } t_phase;

    // Hex digit, either case
    function automatic t_hex hex_val(input logic [7:0] c);
        t_hex  h;
        h = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.valid = 1'b1;
            h.nib   = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.valid = 1'b1;
            h.nib   = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.valid = 1'b1;
            h.nib   = 4'(c - 8'h37);
        end
        return h;
    endfunction

endpackage
`default_nettype wire

@@ rtl/purl_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// purl_front
// Accepts input words, tracks the escape phase and turns each word into a
// group of zero to three output bytes.
// ----------------------------------------------------------------------------
module purl_front import purl_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  wire t_in_word i_in_word,
    input  wire logic     i_q_full,
    output logic          o_full,
    output logic          o_q_push,
    output t_group        o_q_group
);

    t_phase     r_phase, n_phase;
    logic [7:0] r_held,  n_held;
    t_group     grp;
    logic [1:0] k;
    logic       plain;
    t_hex       hc, hh;
    logic       accept;

    assign o_full = i_q_full;
    assign accept = i_push && !i_q_full;
    assign hc     = hex_val(i_in_word.in_char);
    assign hh     = hex_val(r_held);

    // Next phase and byte group for the incoming word
    always_comb begin
        n_phase = r_phase;
        n_held  = r_held;
        grp     = '0;
        k       = 2'd0;
        plain   = 1'b0;
        case (r_phase)
            PH_PCT: begin
                if (hc.valid) begin
                    n_held  = i_in_word.in_char;
                    n_phase = PH_HEX;
                end else begin
                    grp.bytes[0] = CH_PERCENT;
                    k            = 2'd1;
                    plain        = 1'b1;
                end
            end
            PH_HEX: begin
                n_held = '0;
                if (hc.valid) begin
                    grp.bytes[0] = {hh.nib, hc.nib};
                    k            = 2'd1;
                    n_phase      = PH_PLAIN;
                end else begin
                    grp.bytes[0] = CH_PERCENT;
                    grp.bytes[1] = r_held;
                    k            = 2'd2;
                    plain        = 1'b1;
                end
            end
            default: begin
                plain = 1'b1;
            end
        endcase

        // Ordinary character handling
        if (plain) begin
            if (i_in_word.in_char == CH_PERCENT) begin
                n_phase = PH_PCT;
            end else begin
                n_phase = PH_PLAIN;
                grp.bytes[k] = (i_in_word.in_char == CH_PLUS) ? CH_SPACE
                                                              : i_in_word.in_char;
                k = k + 2'd1;
            end
        end

        // End of string flushes a pending escape literally
        if (i_in_word.in_last) begin
            if (n_phase == PH_PCT) begin
                grp.bytes[k] = CH_PERCENT;
                k = k + 2'd1;
            end else if (n_phase == PH_HEX) begin
                grp.bytes[0] = CH_PERCENT;
                grp.bytes[1] = n_held;
                k = 2'd2;
            end
            n_phase  = PH_PLAIN;
            n_held   = '0;
            grp.last = 1'b1;
        end
        grp.cnt = k;
    end

    assign o_q_push  = accept && (k != 2'd0);
    assign o_q_group = grp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PLAIN;
            r_held  <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_held  <= n_held;
        end
    end

endmodule
`default_nettype wire

@@ rtl/purl_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// purl_queue
// Short FIFO of byte groups between the front and the back.
// ----------------------------------------------------------------------------
module purl_queue import purl_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_group i_group,
    input  wire logic   i_pop,
    output logic        o_full,
    output logic        o_empty,
    output t_group      o_head
);

    t_group              r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr, r_rd;
    logic [QCNT_W-1:0]   r_cnt;
    logic                do_push, do_pop;

    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_group;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= r_wr + 1'b1;
            if (do_pop)  r_rd <= r_rd + 1'b1;
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

@@ rtl/purl_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// purl_back
// Walks each queued group one byte at a time into the output register.
// ----------------------------------------------------------------------------
module purl_back import purl_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_q_empty,
    input  wire t_group i_q_head,
    output logic        o_q_pop,
    input  wire logic   i_pop,
    output logic        o_empty,
    output t_out_word   o_out_word
);

    logic [1:0] r_idx, n_idx;
    logic       r_valid;
    t_out_word  r_out;
    logic       load, tail;

    // Output register free or being drained this cycle
    assign load = !i_q_empty && (!r_valid || i_pop);
    assign tail = (r_idx == i_q_head.cnt - 2'd1);

    assign o_q_pop = load && tail;
    assign n_idx   = tail ? 2'd0 : r_idx + 2'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_idx   <= n_idx;
                r_valid <= 1'b1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Output word payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out.out_byte <= i_q_head.bytes[r_idx];
            r_out.out_last <= i_q_head.last && tail;
        end
    end

    assign o_empty    = !r_valid;
    assign o_out_word = r_out;

endmodule
`default_nettype wire

@@ rtl/percent_url_decoder_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// percent_url_decoder_top
// Streaming URL percent-escape decoder in form-urlencoded style.
// ----------------------------------------------------------------------------
// Input is a queue-style port: a word (character plus end-of-string flag)
// is taken on a rising edge with i_push high and o_full low. Output is a
// queue-style port too: the oldest decoded word sits on o_out_word while
// o_empty is low and is taken on an edge with i_pop high.
// '%xx' (either case) becomes one byte, '+' becomes a space, an invalid or
// cut-off escape comes out literally; every string's final byte has
// out_last set. Each input word gives zero to three output words.
// A word's bytes are registered in the group queue, then in the output register.
// Throughput: one input word per cycle while the group queue (four groups)
// has room; the output side drains one byte per cycle, so words giving two
// or three bytes let the queue fill and then hold the input for the extra
// cycles. When the receiver stalls, the output register holds its word and
// the queue fills; o_full then rises and no input is taken.
// Synchronous reset empties the queue and output register and returns the
// decoder to plain-character phase.
// ----------------------------------------------------------------------------
module percent_url_decoder_top import purl_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    output logic          o_full,
    input  wire t_in_word i_in_word,
    output logic          o_empty,
    input  wire logic     i_pop,
    output t_out_word     o_out_word
);

    logic   q_push, q_pop, q_full, q_empty;
    t_group q_in, q_head;

    purl_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (i_push),
        .i_in_word (i_in_word),
        .i_q_full  (q_full),
        .o_full    (o_full),
        .o_q_push  (q_push),
        .o_q_group (q_in)
    );

    purl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_group (q_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    purl_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .i_q_head   (q_head),
        .o_q_pop    (q_pop),
        .i_pop      (i_pop),
        .o_empty    (o_empty),
        .o_out_word (o_out_word)
    );

endmodule
`default_nettype wire

@@ verif/percent_url_decoder_top_test.sv @@
// ----------------------------------------------------------------------------
// percent_url_decoder_top_test
// Self-checking bench for the streaming URL percent-escape decoder.
// ----------------------------------------------------------------------------
// Encoded strings are queued one character word at a time. A driver offers
// them on the push side with random gaps. A monitor takes decoded words on
// the pop side and checks them in order against a software decoder that
// runs on every accepted input word. Directed strings cover escapes in both
// cases, '+', broken and cut-off escapes and byte extremes. They are
// followed by random strings made mostly of well-formed escapes. The
// receiver stalls once for a long stretch, so the block fills and holds off
// its input.
// ----------------------------------------------------------------------------
module percent_url_decoder_top_test;
    import purl_pkg::*;

    localparam int unsigned CHAR_TARGET = 230;
    localparam int unsigned IDLE_PCT    = 36;
    localparam int unsigned HOLD_CYCLES = 150;
    localparam int unsigned HOLD_AFTER  = 60;
    localparam int unsigned QUIET_LIMIT = 2000;
    localparam int unsigned TAIL_CYCLES = 20;
    localparam int unsigned MAX_REPORTS = 10;

    logic      i_clk     = 1'b0;
    logic      i_rst_n   = 1'b0;
    logic      i_push    = 1'b0;
    logic      i_pop     = 1'b0;
    t_in_word  i_in_word = '0;
    logic      o_full;
    logic      o_empty;
    t_out_word o_out_word;

    // Character words still to send, decoded words still to arrive
    t_in_word    encoded_chars[$];
    t_out_word   expected_bytes[$];

    // Software decoder state
    t_phase      dec_phase;
    logic [7:0]  dec_held;
    logic [7:0]  step_bytes[$];

    logic        word_taken = 1'b0;
    logic        byte_taken = 1'b0;
    int unsigned in_count   = 0;
    int unsigned out_count  = 0;
    int unsigned error_count = 0;
    int unsigned hold_left  = 0;
    logic        hold_done  = 1'b0;
    t_in_word    spent_word;
    t_out_word   want_word;

    percent_url_decoder_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_push),
        .o_full     (o_full),
        .i_in_word  (i_in_word),
        .o_empty    (o_empty),
        .i_pop      (i_pop),
        .o_out_word (o_out_word)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------

    // Hex digit value, either case; -1 if not a digit
    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
        if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
        if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
        return -1;
    endfunction

    // Character seen in plain phase
    task automatic plain_decode(input logic [7:0] c);
        if (c == CH_PERCENT) begin
            dec_phase = PH_PCT;
        end else if (c == CH_PLUS) begin
            step_bytes.push_back(CH_SPACE);
        end else begin
            step_bytes.push_back(c);
        end
    endtask

    // Decode one accepted word and queue the bytes it should give
    task automatic decode_char_word(input t_in_word w);
        int        lo_nib;
        int        hi_nib;
        t_out_word ow;
        step_bytes.delete();
        lo_nib = hex_nibble(w.in_char);
        case (dec_phase)
            PH_PCT: begin
                if (lo_nib >= 0) begin
                    dec_held  = w.in_char;
                    dec_phase = PH_HEX;
                end else begin
                    step_bytes.push_back(CH_PERCENT);
                    dec_phase = PH_PLAIN;
                    plain_decode(w.in_char);
                end
            end
            PH_HEX: begin
                if (lo_nib >= 0) begin
                    hi_nib = hex_nibble(dec_held);
                    if (hi_nib < 0) hi_nib = 0;
                    step_bytes.push_back({4'(hi_nib), 4'(lo_nib)});
                    dec_phase = PH_PLAIN;
                end else begin
                    // bad second digit: '%' and held digit come out as text
                    step_bytes.push_back(CH_PERCENT);
                    step_bytes.push_back(dec_held);
                    dec_phase = PH_PLAIN;
                    plain_decode(w.in_char);
                end
                if (dec_phase != PH_HEX) dec_held = '0;
            end
            default: begin
                dec_phase = PH_PLAIN;
                plain_decode(w.in_char);
            end
        endcase
        // end of string flushes an open escape literally
        if (w.in_last) begin
            if (dec_phase == PH_PCT) begin
                step_bytes.push_back(CH_PERCENT);
            end else if (dec_phase == PH_HEX) begin
                step_bytes.push_back(CH_PERCENT);
                step_bytes.push_back(dec_held);
            end
            dec_phase = PH_PLAIN;
            dec_held  = '0;
        end
        foreach (step_bytes[i]) begin
            ow.out_byte = step_bytes[i];
            ow.out_last = w.in_last && (i == step_bytes.size() - 1);
            expected_bytes.push_back(ow);
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_char(input logic [7:0] c, input logic last);
        t_in_word w;
        w.in_char = c;
        w.in_last = last;
        encoded_chars.push_back(w);
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++) queue_char(s[i], i == s.len() - 1);
    endtask

    function automatic logic [7:0] random_hex_char();
        int unsigned n;
        n = $urandom_range(15);
        if (n < 10) return 8'(8'h30 + n);
        return $urandom_range(1) ? 8'(8'h41 + n - 10) : 8'(8'h61 + n - 10);
    endfunction

    function automatic logic [7:0] random_non_hex();
        logic [7:0] c;
        c = 8'($urandom_range(255));
        while (hex_nibble(c) >= 0) c = 8'($urandom_range(255));
        return c;
    endfunction

    // Random string: mostly good escapes, some broken ones and noise
    task automatic queue_random_string();
        logic [7:0]  text[$];
        int unsigned target;
        int unsigned pick;
        target = $urandom_range(1, 8);
        while (text.size() < target) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                text.push_back(CH_PERCENT);
                text.push_back(random_hex_char());
                text.push_back(random_hex_char());
            end else if (pick < 52) begin
                text.push_back(CH_PERCENT);
                text.push_back(random_hex_char());
                text.push_back(random_non_hex());
            end else if (pick < 58) begin
                text.push_back(CH_PERCENT);
                text.push_back(random_non_hex());
            end else if (pick < 66) begin
                text.push_back(CH_PLUS);
            end else if (pick < 74) begin
                text.push_back(CH_PERCENT);
            end else begin
                text.push_back(8'($urandom_range(255)));
            end
        end
        foreach (text[i]) queue_char(text[i], i == text.size() - 1);
    endtask

    task automatic note_error(input string what, input t_out_word want,
                              input t_out_word got);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("ERROR %s: expected byte %02h last %0b, got byte %02h last %0b",
                     what, want.out_byte, want.out_last, got.out_byte, got.out_last);
    endtask

    // ------------------------------------------------------------------
    // Monitor: check output words, then model accepted input words
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        word_taken = 1'b0;
        byte_taken = 1'b0;
        if (i_rst_n) begin
            if (i_pop && !o_empty) begin
                byte_taken = 1'b1;
                out_count++;
                if (expected_bytes.size() == 0) begin
                    note_error("unexpected word", '0, o_out_word);
                end else begin
                    want_word = expected_bytes.pop_front();
                    if (o_out_word.out_byte != want_word.out_byte ||
                        o_out_word.out_last != want_word.out_last)
                        note_error("mismatch", want_word, o_out_word);
                end
            end
            if (i_push && !o_full) begin
                word_taken = 1'b1;
                in_count++;
                decode_char_word(i_in_word);
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: offer queued words with random gaps
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (word_taken) spent_word = encoded_chars.pop_front();
        if (!i_rst_n || encoded_chars.size() == 0) begin
            i_push <= 1'b0;
        end else if (!(in_count >= 120 && in_count < 170) &&
                     $urandom_range(99) < IDLE_PCT) begin
            i_push <= 1'b0;
        end else begin
            i_push    <= 1'b1;
            i_in_word <= encoded_chars[0];
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random pops, one long hold-off to back the block up
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_pop <= 1'b0;
        end else if (hold_left > 0) begin
            i_pop <= 1'b0;
            hold_left--;
        end else if (!hold_done && out_count >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            i_pop <= 1'b0;
        end else if (!(out_count >= 150 && out_count < 220) &&
                     $urandom_range(99) < IDLE_PCT) begin
            i_pop <= 1'b0;
        end else begin
            i_pop <= 1'b1;
        end
    end

    // Watchdog on cycles with no traffic on either side
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(negedge i_clk);
            if (word_taken || byte_taken) quiet = 0;
            else quiet++;
        end
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sequence: build stimulus, reset, wait for drain, report
    // ------------------------------------------------------------------
    initial begin
        dec_phase = PH_PLAIN;
        dec_held  = '0;

        // escapes in both cases
        queue_text("%4a");
        queue_text("%Ff");
        // non-hex after '%', and after one digit (three bytes out)
        queue_text("%+");
        queue_text("%4+");
        // '%' as the bad character restarts an escape
        queue_text("%%");
        queue_text("%9%");
        // string ends inside an escape
        queue_text("%A");
        queue_text("%");
        // byte extremes and '+' in plain phase
        queue_char(8'h00, 1'b0);
        queue_char(8'hFF, 1'b0);
        queue_char(CH_PLUS, 1'b1);

        while (encoded_chars.size() < CHAR_TARGET) queue_random_string();

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (encoded_chars.size() != 0 || expected_bytes.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (error_count == 0 && expected_bytes.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
